[rtl/sbr_pkg.sv]
// Shared types, constants and sequencer helpers for the sensor batch reassembly block.
package sbr_pkg;

   localparam int unsigned SENSOR_COUNT = 8;
   localparam int unsigned SENSOR_W     = 3;
   localparam int unsigned BATCH_DEPTH  = 64;
   localparam int unsigned POS_W        = 6;
   localparam int unsigned SAMPLES_PER_PACKET = 3;
   localparam int unsigned STORE_DEPTH  = SENSOR_COUNT * BATCH_DEPTH;
   localparam int unsigned STORE_AW     = 9;
   localparam int unsigned MAX_RESULTS  = 64;
   localparam int unsigned COUNT_W      = 7;
   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned ID_W         = 29;
   localparam int unsigned OFFSET_W     = 10;

   localparam logic [1:0] KIND_SAMPLE      = 2'd0;
   localparam logic [1:0] KIND_INTERRUPTED = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW    = 2'd2;
   localparam logic [1:0] KIND_EMPTY       = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILTER,
      ST_UPDATE,
      ST_INTR,
      ST_WRITE,
      ST_REJECT,
      ST_EMPTY,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]     frame_id;
      logic                remote_request;
      logic [7:0]          batch_number;
      logic [7:0]          pkt_seq;
      logic [1:0]          chunk_length;
      logic                batch_end;
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_c;
   } item_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SENSOR_W-1:0] sensor_index;
      logic [7:0]          batch_tag;
      logic [POS_W-1:0]    position;
      logic [SAMPLE_W-1:0] value;
      logic [7:0]          received_count;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [STORE_AW-1:0] wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic                rd_en;
      logic [STORE_AW-1:0] rd_addr;
   } store_cmd_type;

   // where to go once the batch has been updated and written
   function automatic state_type done_state(logic complete, logic empty);
      state_type s;
      if (!complete) begin
         s = ST_IDLE;
      end else if (empty) begin
         s = ST_EMPTY;
      end else begin
         s = ST_EMIT_RD;
      end
      return s;
   endfunction

   // where to go after an optional interrupted notice
   function automatic state_type body_state(logic reject, logic has_data,
                                            logic complete, logic empty);
      state_type s;
      if (reject) begin
         s = ST_REJECT;
      end else if (has_data) begin
         s = ST_WRITE;
      end else begin
         s = done_state(complete, empty);
      end
      return s;
   endfunction

endpackage

[rtl/sbr_sample_store.sv]
// Sample store RAM: one write port, one read port with registered read data.
module sbr_sample_store
   import sbr_pkg::*;
(
   input  logic                clock,
   input  store_cmd_type       cmd,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sensor_batch_reassembly_top.sv]
// Top level of the sensor batch reassembly block: sequencer, per-sensor state, result register.
//
// Usage
//   req_* carries one received CAN frame per item (valid/stall). Frames that are remote
//   requests or whose id, sensor index masked off, differs from csr_write_data as last
//   written (packet_type_id) produce no result. Accepted packets update the sensor's batch
//   state and store up to three samples; results leave on rsp_* (valid/stall), rsp_last
//   marks the final result of one item.
//   csr_write_enable writes packet_type_id; write it only while idle.
// Sequencing
//   One item at a time; req_stall is low only when the sequencer is idle.
//   Dropped frame: filter, then idle. Accepted packet: decode and state update, then an
//   optional interrupted notice, then an overflow notice or one write per stored sample
//   (0..3); a completed batch then ends in an empty notice or drains N samples (N <= 64)
//   via a read ahead and one read per result; the shared index/address adder sets this order.
// Reset
//   Synchronous, active high. Afterwards all 512 store entries are zeroed one entry per cycle
//   while req_stall stays high; csr writes are taken during that sweep.
// Stall
//   The result register holds while rsp_stall is high and the sequencer waits with it;
//   nothing is lost or repeated.
module sensor_batch_reassembly_top
   import sbr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [ID_W-1:0]            csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ID_W-1:0]            req_frame_id,
   input  logic                       req_remote_request,
   input  logic [7:0]                 req_batch_number,
   input  logic [7:0]                 req_pkt_seq,
   input  logic [1:0]                 req_chunk_length,
   input  logic                       req_batch_end,
   input  logic signed [SAMPLE_W-1:0] req_sample_a,
   input  logic signed [SAMPLE_W-1:0] req_sample_b,
   input  logic signed [SAMPLE_W-1:0] req_sample_c,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic [SENSOR_W-1:0]        rsp_sensor_index,
   output logic [7:0]                 rsp_batch_tag,
   output logic [POS_W-1:0]           rsp_position,
   output logic signed [SAMPLE_W-1:0] rsp_value,
   output logic [7:0]                 rsp_received_count,
   output logic                       rsp_last
);

   // control state
   state_type            state_ff, state_in;
   logic [ID_W-1:0]      pkt_type_ff, pkt_type_in;
   logic [STORE_AW-1:0]  clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           cur_batch_ff [SENSOR_COUNT];
   logic [7:0]           cur_batch_in [SENSOR_COUNT];
   logic [7:0]           got_ff [SENSOR_COUNT];
   logic [7:0]           got_in [SENSOR_COUNT];
   logic [8:0]           due_ff [SENSOR_COUNT];
   logic [8:0]           due_in [SENSOR_COUNT];
   logic [COUNT_W-1:0]   scnt_ff [SENSOR_COUNT];
   logic [COUNT_W-1:0]   scnt_in [SENSOR_COUNT];

   // payload / per-item working registers
   item_type             item_ff, item_in;
   rsp_type              rsp_ff, rsp_in;
   logic [SENSOR_W-1:0]  sensor_ff, sensor_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic                 intr_ff, intr_in;
   logic                 reject_ff, reject_in;
   logic                 complete_ff, complete_in;
   logic                 empty_ff, empty_in;
   logic [7:0]           old_batch_ff, old_batch_in;
   logic [7:0]           old_got_ff, old_got_in;
   logic [COUNT_W-1:0]   n_emit_ff, n_emit_in;
   logic [COUNT_W-1:0]   idx_ff, idx_in;

   store_cmd_type        store_cmd;
   logic [SAMPLE_W-1:0]  store_rd_data;

   // combinational helpers
   logic                 out_free;
   logic                 accept;
   logic                 frame_keep;
   logic [COUNT_W-1:0]   idx_inc;
   logic [POS_W-1:0]     add_a, add_b, pos_sum;
   logic [SAMPLE_W-1:0]  wr_sample;

   // batch update, evaluated in ST_UPDATE
   logic [7:0]           u_batch, u_got0, u_got1;
   logic [8:0]           u_due, u_due0, u_due1;
   logic [COUNT_W-1:0]   u_cnt0, u_cnt1, u_lim;
   logic [COUNT_W:0]     u_csum;
   logic [1:0]           u_prior;
   logic                 u_new, u_intr, u_rej, u_comp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_inc   = idx_ff + COUNT_W'(1);

   // frame filter: sensor index sits in the low id bits
   assign frame_keep = !item_ff.remote_request &&
      ({item_ff.frame_id[ID_W-1:SENSOR_W], {SENSOR_W{1'b0}}} == pkt_type_ff);

   // shared position adder: write offset + index, read index, or read index + 1
   always_comb begin
      case (state_ff)
         ST_WRITE: begin
            add_a = offset_ff[POS_W-1:0];
            add_b = idx_ff[POS_W-1:0];
         end
         ST_EMIT_LD: begin
            add_a = idx_ff[POS_W-1:0];
            add_b = POS_W'(1);
         end
         default: begin
            add_a = idx_ff[POS_W-1:0];
            add_b = '0;
         end
      endcase
   end
   assign pos_sum = add_a + add_b;

   always_comb begin
      case (idx_ff[1:0])
         2'd0:    wr_sample = item_ff.sample_a;
         2'd1:    wr_sample = item_ff.sample_b;
         default: wr_sample = item_ff.sample_c;
      endcase
   end

   // batch state update for the current sensor
   always_comb begin
      u_batch = cur_batch_ff[sensor_ff];
      u_new   = (u_batch != item_ff.batch_number);
      u_intr  = u_new && ({1'b0, got_ff[sensor_ff]} != due_ff[sensor_ff]);
      u_got0  = u_new ? 8'd0 : got_ff[sensor_ff];
      u_due0  = u_new ? 9'd0 : due_ff[sensor_ff];
      u_cnt0  = u_new ? '0 : scnt_ff[sensor_ff];
      u_rej   = ({1'b0, offset_ff} + (OFFSET_W+1)'(item_ff.chunk_length)) >
                (OFFSET_W+1)'(BATCH_DEPTH);
      u_csum  = {1'b0, u_cnt0} + (COUNT_W+1)'(item_ff.chunk_length);
      if (u_rej) begin
         u_got1 = u_got0;
         u_cnt1 = u_cnt0;
         u_due1 = u_due0;
      end else begin
         u_got1 = (u_got0 == 8'hFF) ? u_got0 : u_got0 + 8'd1;
         u_cnt1 = (u_csum > (COUNT_W+1)'(BATCH_DEPTH)) ? COUNT_W'(BATCH_DEPTH)
                                                      : u_csum[COUNT_W-1:0];
         u_due1 = item_ff.batch_end ? {1'b0, item_ff.pkt_seq} + 9'd1 : u_due0;
      end
      u_due   = u_due1;
      u_comp  = ({1'b0, u_got1} == u_due);
      // notices ahead of the samples eat into the per-item result budget
      u_prior = {1'b0, u_intr} + {1'b0, u_rej};
      u_lim   = COUNT_W'(MAX_RESULTS) - COUNT_W'(u_prior);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == STORE_AW'(STORE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_FILTER;
         end
         ST_FILTER: begin
            state_in = frame_keep ? ST_UPDATE : ST_IDLE;
         end
         ST_UPDATE: begin
            if (u_intr) begin
               state_in = ST_INTR;
            end else begin
               state_in = body_state(u_rej, item_ff.chunk_length != 2'd0,
                                     u_comp, u_cnt1 == '0);
            end
         end
         ST_INTR: begin
            if (out_free) begin
               state_in = body_state(reject_ff, item_ff.chunk_length != 2'd0,
                                     complete_ff, empty_ff);
            end
         end
         ST_WRITE: begin
            if (idx_inc == COUNT_W'(item_ff.chunk_length)) begin
               state_in = done_state(complete_ff, empty_ff);
            end
         end
         ST_REJECT: begin
            if (out_free) state_in = done_state(complete_ff, empty_ff);
         end
         ST_EMPTY: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free && idx_inc == n_emit_ff) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pkt_type_in  = csr_write_enable ? csr_write_data : pkt_type_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      sensor_in    = sensor_ff;
      offset_in    = offset_ff;
      intr_in      = intr_ff;
      reject_in    = reject_ff;
      complete_in  = complete_ff;
      empty_in     = empty_ff;
      old_batch_in = old_batch_ff;
      old_got_in   = old_got_ff;
      n_emit_in    = n_emit_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cur_batch_in = cur_batch_ff;
      got_in       = got_ff;
      due_in       = due_ff;
      scnt_in      = scnt_ff;
      store_cmd    = '0;

      case (state_ff)
         ST_CLEAR: begin
            store_cmd.wr_en   = 1'b1;
            store_cmd.wr_addr = clr_ff;
            store_cmd.wr_data = '0;
            clr_in            = clr_ff + STORE_AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               item_in.frame_id        = req_frame_id;
               item_in.remote_request  = req_remote_request;
               item_in.batch_number    = req_batch_number;
               item_in.pkt_seq         = req_pkt_seq;
               item_in.chunk_length    = req_chunk_length;
               item_in.batch_end       = req_batch_end;
               item_in.sample_a        = req_sample_a;
               item_in.sample_b        = req_sample_b;
               item_in.sample_c        = req_sample_c;
            end
         end
         ST_FILTER: begin
            sensor_in = item_ff.frame_id[SENSOR_W-1:0];
            // sequence * 3
            offset_in = {1'b0, item_ff.pkt_seq, 1'b0} +
                        {2'b0, item_ff.pkt_seq};
         end
         ST_UPDATE: begin
            intr_in                 = u_intr;
            reject_in               = u_rej;
            complete_in             = u_comp;
            empty_in                = (u_cnt1 == '0);
            old_batch_in            = u_batch;
            old_got_in              = got_ff[sensor_ff];
            n_emit_in               = (u_cnt1 < u_lim) ? u_cnt1 : u_lim;
            idx_in                  = '0;
            cur_batch_in[sensor_ff] = item_ff.batch_number;
            got_in[sensor_ff]       = u_got1;
            due_in[sensor_ff]       = u_due1;
            scnt_in[sensor_ff]      = u_cnt1;
         end
         ST_INTR: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_INTERRUPTED;
               rsp_in.sensor_index   = sensor_ff;
               rsp_in.batch_tag      = old_batch_ff;
               rsp_in.position       = '0;
               rsp_in.value          = '0;
               rsp_in.received_count = old_got_ff;
               rsp_in.last           = !reject_ff && !complete_ff;
            end
         end
         ST_WRITE: begin
            store_cmd.wr_en   = 1'b1;
            store_cmd.wr_addr = {sensor_ff, pos_sum};
            store_cmd.wr_data = wr_sample;
            idx_in            = (idx_inc == COUNT_W'(item_ff.chunk_length)) ? '0 : idx_inc;
         end
         ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_OVERFLOW;
               rsp_in.sensor_index   = sensor_ff;
               rsp_in.batch_tag      = item_ff.batch_number;
               rsp_in.position       = item_ff.pkt_seq[POS_W-1:0];
               rsp_in.value          = '0;
               rsp_in.received_count = '0;
               rsp_in.last           = !complete_ff;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_EMPTY;
               rsp_in.sensor_index   = sensor_ff;
               rsp_in.batch_tag      = item_ff.batch_number;
               rsp_in.position       = '0;
               rsp_in.value          = '0;
               rsp_in.received_count = '0;
               rsp_in.last           = 1'b1;
            end
         end
         ST_EMIT_RD: begin
            store_cmd.rd_en   = 1'b1;
            store_cmd.rd_addr = {sensor_ff, pos_sum};
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_SAMPLE;
               rsp_in.sensor_index   = sensor_ff;
               rsp_in.batch_tag      = item_ff.batch_number;
               rsp_in.position       = idx_ff[POS_W-1:0];
               rsp_in.value          = store_rd_data;
               rsp_in.received_count = '0;
               rsp_in.last           = (idx_inc == n_emit_ff);
               idx_in                = idx_inc;
               // prefetch the next sample while this one goes out
               store_cmd.rd_en       = (idx_inc != n_emit_ff);
               store_cmd.rd_addr     = {sensor_ff, pos_sum};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pkt_type_ff  <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            cur_batch_ff[i] <= '0;
            got_ff[i]       <= '0;
            due_ff[i]       <= '0;
            scnt_ff[i]      <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pkt_type_ff  <= pkt_type_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_batch_ff <= cur_batch_in;
         got_ff       <= got_in;
         due_ff       <= due_in;
         scnt_ff      <= scnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rsp_ff       <= rsp_in;
      sensor_ff    <= sensor_in;
      offset_ff    <= offset_in;
      intr_ff      <= intr_in;
      reject_ff    <= reject_in;
      complete_ff  <= complete_in;
      empty_ff     <= empty_in;
      old_batch_ff <= old_batch_in;
      old_got_ff   <= old_got_in;
      n_emit_ff    <= n_emit_in;
      idx_ff       <= idx_in;
   end

   sbr_sample_store u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .rd_data (store_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_sensor_index   = rsp_ff.sensor_index;
   assign rsp_batch_tag      = rsp_ff.batch_tag;
   assign rsp_position       = rsp_ff.position;
   assign rsp_value          = rsp_ff.value;
   assign rsp_received_count = rsp_ff.received_count;
   assign rsp_last           = rsp_ff.last;

   // store port is never asked to write and read in the same cycle
   a_store_one_op: assert property (@(posedge clock) disable iff (reset)
      !(store_cmd.wr_en && store_cmd.rd_en))
      else $error("store write and read in one cycle");

   // an accepted item always goes to the filter stage next
   a_accept_filter: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_FILTER))
      else $error("accepted item not decoded");

   // sample writes stay inside the sensor's batch area
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |->
         (({1'b0, offset_ff} + (OFFSET_W+1)'(idx_ff)) < (OFFSET_W+1)'(BATCH_DEPTH)))
      else $error("sample write past batch depth");

   // emission index stays below the emission count
   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_LD)) |-> (idx_ff < n_emit_ff))
      else $error("emission index out of range");

endmodule
